>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge, with checking off while arst_n is low.
`define LZ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every rising clk edge, reset included.
`define LZ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// Types, constants and command codes for the LZSS stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package lzss_pkg;

	// Ring window geometry
	localparam int unsigned RING_DEPTH = 4096;
	localparam int unsigned RING_AW    = $clog2(RING_DEPTH);
	localparam logic [RING_AW-1:0] START_POS = RING_AW'(RING_DEPTH - 18);
	localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);

	// Output count and limit
	localparam int unsigned COUNT_W = 24;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// Token geometry
	localparam int unsigned LEN_W = 5;
	localparam logic [LEN_W-1:0] MIN_MATCH  = LEN_W'(3);
	localparam logic [LEN_W-1:0] LEN_ONE    = LEN_W'(1);
	localparam logic [3:0]       FLAG_COUNT = 4'd8;

	// Input beat
	typedef struct packed {
		logic       command;
		logic [7:0] in_byte;
		logic       last_byte;
	} in_item_t;

	// Output beat
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	// Input command codes
	localparam logic CMD_DATA  = 1'b0;
	localparam logic CMD_START = 1'b1;

	// Controller states
	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_READ  = 4'b0100,
		ST_WRITE = 4'b1000
	} state_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_START,
		OP_CLEAR,
		OP_FLAGS,
		OP_LITERAL,
		OP_PAIR_LO,
		OP_PAIR_HI,
		OP_READ,
		OP_COPY
	} dp_op_t;

	// Controller to datapath
	typedef struct packed {
		dp_op_t op;
		logic   set_done;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic stream_done;
		logic awaiting;
		logic flags_empty;
		logic flag_bit0;
		logic limit_hit;
		logic copy_last;
		logic clear_last;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/lzss_ram.sv
// ----------------------------------------------------------------------------
// lzss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/lzss_ctrl.sv
// ----------------------------------------------------------------------------
// lzss_ctrl
// Controller: accepts input beats, sequences clearing passes and match copies,
// and issues one datapath operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output      logic                 item_ready,
	input  wire logic                 item_command,
	input  wire logic                 item_last,
	input  wire lzss_pkg::dp_status_t status,
	output      lzss_pkg::dp_cmd_t    cmd
);

	lzss_pkg::state_t state_q, state_d;

	// Decide the next operation
	always_comb begin
		state_d      = state_q;
		item_ready   = 1'b0;
		cmd.op       = lzss_pkg::OP_NONE;
		cmd.set_done = 1'b0;
		unique case (state_q)
			lzss_pkg::ST_CLEAR: begin
				cmd.op = lzss_pkg::OP_CLEAR;
				if (status.clear_last) begin
					state_d = lzss_pkg::ST_IDLE;
				end
			end
			lzss_pkg::ST_IDLE: begin
				item_ready = status.out_free;
				if (item_valid && status.out_free) begin
					if (item_command == lzss_pkg::CMD_START) begin
						cmd.op  = lzss_pkg::OP_START;
						state_d = lzss_pkg::ST_CLEAR;
					end else if (!status.stream_done) begin
						cmd.set_done = item_last;
						if (status.awaiting) begin
							cmd.op  = lzss_pkg::OP_PAIR_HI;
							state_d = lzss_pkg::ST_READ;
						end else if (status.flags_empty) begin
							cmd.op = lzss_pkg::OP_FLAGS;
						end else if (status.limit_hit) begin
							// limit reached: end the stream, drop the beat
							cmd.set_done = 1'b1;
						end else if (status.flag_bit0) begin
							cmd.op = lzss_pkg::OP_LITERAL;
						end else begin
							cmd.op = lzss_pkg::OP_PAIR_LO;
						end
					end
				end
			end
			lzss_pkg::ST_READ: begin
				cmd.op  = lzss_pkg::OP_READ;
				state_d = lzss_pkg::ST_WRITE;
			end
			lzss_pkg::ST_WRITE: begin
				// hold the fetched byte until the output register is free
				if (status.out_free) begin
					cmd.op  = lzss_pkg::OP_COPY;
					state_d = status.copy_last ? lzss_pkg::ST_IDLE : lzss_pkg::ST_READ;
				end
			end
			default: begin
				state_d = lzss_pkg::ST_CLEAR;
			end
		endcase
	end

	// State register; reset starts a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lzss_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/lzss_dp.sv
// ----------------------------------------------------------------------------
// lzss_dp
// Datapath: ring window, token state, output count and limit, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire lzss_pkg::dp_cmd_t                     cmd,
	output      lzss_pkg::dp_status_t                  status,
	input  wire logic [7:0]                            in_byte,
	input  wire logic                                  cfg_wr_en,
	input  wire logic [lzss_pkg::COUNT_W-1:0]          cfg_wr_data,
	output      logic                                  result_valid,
	input  wire logic                                  result_ready,
	output      lzss_pkg::out_item_t                   result
);

	logic [lzss_pkg::RING_AW-1:0] wpos_q;
	logic [lzss_pkg::RING_AW-1:0] clear_addr_q;
	logic [lzss_pkg::RING_AW-1:0] src_q;
	logic [7:0]                   flag_bits_q;
	logic [3:0]                   flags_left_q;
	logic [7:0]                   pending_q;
	logic                         awaiting_q;
	logic [lzss_pkg::COUNT_W-1:0] count_q;
	logic [lzss_pkg::COUNT_W-1:0] limit_q;
	logic                         done_q;
	logic [lzss_pkg::LEN_W-1:0]   copy_left_q;
	logic                         out_valid_q;
	lzss_pkg::out_item_t          out_q;

	logic                         ram_we;
	logic [lzss_pkg::RING_AW-1:0] ram_waddr;
	logic [7:0]                   ram_wdata;
	logic                         ram_re;
	logic [7:0]                   ram_rdata;
	logic                         out_free;
	logic                         emit;
	logic                         use_flag;

	assign out_free = !out_valid_q || result_ready;
	assign emit     = (cmd.op == lzss_pkg::OP_LITERAL) || (cmd.op == lzss_pkg::OP_COPY);
	assign use_flag = (cmd.op == lzss_pkg::OP_LITERAL) || (cmd.op == lzss_pkg::OP_PAIR_HI);

	// Ring write and read selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wpos_q;
		ram_wdata = in_byte;
		ram_re    = (cmd.op == lzss_pkg::OP_READ);
		case (cmd.op)
			lzss_pkg::OP_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clear_addr_q;
				ram_wdata = 8'd0;
			end
			lzss_pkg::OP_LITERAL: begin
				ram_we = 1'b1;
			end
			lzss_pkg::OP_COPY: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	lzss_ram #(
		.WIDTH (8),
		.DEPTH (lzss_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (src_q),
		.rdata (ram_rdata)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q       <= lzss_pkg::START_POS;
			clear_addr_q <= '0;
			flag_bits_q  <= '0;
			flags_left_q <= '0;
			awaiting_q   <= 1'b0;
			count_q      <= '0;
			limit_q      <= lzss_pkg::COUNT_MAX;
			done_q       <= 1'b0;
			copy_left_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (cmd.set_done) begin
				done_q <= 1'b1;
			end
			// advance write position and count on each output byte
			if (emit) begin
				wpos_q <= wpos_q + 1'b1;
				if (count_q != lzss_pkg::COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (use_flag) begin
				flag_bits_q <= {1'b0, flag_bits_q[7:1]};
				if (flags_left_q != 4'd0) begin
					flags_left_q <= flags_left_q - 1'b1;
				end
			end
			// output register: load on emit, drop on a taken beat
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				lzss_pkg::OP_START: begin
					wpos_q       <= lzss_pkg::START_POS;
					clear_addr_q <= '0;
					flag_bits_q  <= '0;
					flags_left_q <= '0;
					awaiting_q   <= 1'b0;
					count_q      <= '0;
					done_q       <= 1'b0;
				end
				lzss_pkg::OP_CLEAR: begin
					clear_addr_q <= clear_addr_q + 1'b1;
				end
				lzss_pkg::OP_FLAGS: begin
					flag_bits_q  <= in_byte;
					flags_left_q <= lzss_pkg::FLAG_COUNT;
				end
				lzss_pkg::OP_PAIR_LO: begin
					awaiting_q <= 1'b1;
				end
				lzss_pkg::OP_PAIR_HI: begin
					awaiting_q  <= 1'b0;
					copy_left_q <= lzss_pkg::LEN_W'(in_byte[3:0]) + lzss_pkg::MIN_MATCH;
				end
				lzss_pkg::OP_COPY: begin
					copy_left_q <= copy_left_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.op == lzss_pkg::OP_PAIR_LO) begin
			pending_q <= in_byte;
		end
		if (cmd.op == lzss_pkg::OP_PAIR_HI) begin
			src_q <= {in_byte[7:4], pending_q};
		end else if (cmd.op == lzss_pkg::OP_COPY) begin
			src_q <= src_q + 1'b1;
		end
		if (cmd.op == lzss_pkg::OP_LITERAL) begin
			out_q.out_byte    <= in_byte;
			out_q.last_of_run <= 1'b1;
		end else if (cmd.op == lzss_pkg::OP_COPY) begin
			out_q.out_byte    <= ram_rdata;
			out_q.last_of_run <= (copy_left_q == lzss_pkg::LEN_ONE);
		end
	end

	// Status to the controller
	always_comb begin
		status.stream_done = done_q;
		status.awaiting    = awaiting_q;
		status.flags_empty = (flags_left_q == 4'd0);
		status.flag_bit0   = flag_bits_q[0];
		status.limit_hit   = (limit_q != lzss_pkg::COUNT_MAX) && (count_q >= limit_q);
		status.copy_last   = (copy_left_q == lzss_pkg::LEN_ONE);
		status.clear_last  = (clear_addr_q == lzss_pkg::RING_LAST);
		status.out_free    = out_free;
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/lzss_decompressor_top.sv
// ----------------------------------------------------------------------------
// lzss_decompressor_top
// LZSS stream decoder with a 4096-byte ring window addressed absolutely.
//
//   Channel   Signals                                    Beat
//   item      item_valid / item_ready / item             one compressed byte or start
//   result    result_valid / result_ready / result       one decoded byte
//   cfg       cfg_wr_en / cfg_wr_data                    output_limit write
//
// A flag byte, the first byte of a pair, a literal or an ignored byte is taken
// without leaving the idle state. The second byte of a pair starts a copy: each
// copied byte is a registered ring read followed by a ring write and output load.
// Reset and every start command run a clearing pass over all 4096 ring entries,
// one entry a cycle, with item_ready low; cfg writes are taken meanwhile.
// A result beat left waiting holds the copy and keeps item_ready low.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_decompressor_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output      logic                         item_ready,
	input  wire lzss_pkg::in_item_t           item,
	output      logic                         result_valid,
	input  wire logic                         result_ready,
	output      lzss_pkg::out_item_t          result,
	input  wire logic                         cfg_wr_en,
	input  wire logic [lzss_pkg::COUNT_W-1:0] cfg_wr_data
);

	lzss_pkg::dp_cmd_t    cmd;
	lzss_pkg::dp_status_t status;

	lzss_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item_command (item.command),
		.item_last    (item.last_byte),
		.status       (status),
		.cmd          (cmd)
	);

	lzss_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.in_byte      (item.in_byte),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> hw/rtl/lzss_chk.sv
// ----------------------------------------------------------------------------
// lzss_chk
// Port-level checker for the LZSS decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lzss_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                item_valid,
	input wire logic                item_ready,
	input wire lzss_pkg::in_item_t  item,
	input wire logic                result_valid,
	input wire logic                result_ready,
	input wire lzss_pkg::out_item_t result
);

	// A stalled result beat keeps its payload
	`LZ_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result changed while stalled")

	// Never take an input while a result waits untaken
	`LZ_ASSERT(a_ready_needs_room, item_ready |-> !result_valid || result_ready, "item_ready with blocked output")

	// A start command is followed by the clearing pass
	`LZ_ASSERT(a_start_clears, item_valid && item_ready && (item.command == lzss_pkg::CMD_START) |=> !item_ready, "no clearing pass after start")

	// A new result comes from an accepted beat or from ongoing work
	`LZ_ASSERT(a_no_stray_result, $rose(result_valid) |-> $past(!item_ready || item_valid), "result from an idle block")

endmodule

bind lzss_decompressor_top lzss_chk u_chk (.*);

`default_nettype wire
